FILE: hdl/ddtc_pkg.sv
// ----------------------------------------------------------------------------
// ddtc_pkg
// Types and constants shared by the download transfer control modules.
// ----------------------------------------------------------------------------
package ddtc_pkg;

	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 8;
	localparam int LEN_W     = 12;
	localparam int LIM_CMP_W = 16;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [LEN_W-1:0] MAX_BLOCK_LENGTH_RST = 12'd1024;

	localparam logic [1:0] CMD_REQ_DOWNLOAD = 2'd0;
	localparam logic [1:0] CMD_TRANSFER     = 2'd1;
	localparam logic [1:0] CMD_EXIT         = 2'd2;

	typedef enum logic [1:0] {
		KIND_DOWNLOAD,
		KIND_TRANSFER,
		KIND_EXIT,
		KIND_BAD
	} kind_t;

	typedef enum logic [1:0] {
		NEG_NONE,
		NEG_SEQUENCE,
		NEG_COUNTER,
		NEG_LENGTH
	} neg_code_t;

	typedef struct packed {
		kind_t              kind;
		logic [CNT_W-1:0]   block_counter;
		logic [LEN_W-1:0]   payload_bytes;
		logic [ADDR_W-1:0]  start_address;
		logic [ADDR_W-1:0]  total_length;
		logic               target_ok;
		logic               payload_too_big;
	} item_t;

	typedef struct packed {
		logic               positive;
		neg_code_t          neg_code;
		logic [CNT_W-1:0]   echo_counter;
		logic               write_enable;
		logic [ADDR_W-1:0]  write_address;
		logic [LEN_W-1:0]   write_length;
		logic [LEN_W-1:0]   block_limit;
	} result_t;

endpackage

FILE: hdl/ddtc_front.sv
// ----------------------------------------------------------------------------
// ddtc_front
// Input stage: take request words, classify them and hand them to the queue.
// ----------------------------------------------------------------------------
module ddtc_front
	import ddtc_pkg::*;
#(
	parameter int MAX_BLOCK_BYTES = 4095
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [CNT_W-1:0]   block_counter,
	input  logic [LEN_W-1:0]   payload_bytes,
	input  logic [ADDR_W-1:0]  start_address,
	input  logic [ADDR_W-1:0]  total_length,
	input  logic               target_ok,
	output logic               push_valid,
	input  logic               push_ready,
	output item_t              push_item
);

	localparam logic [LIM_CMP_W-1:0] MAX_W = LIM_CMP_W'(MAX_BLOCK_BYTES);

	logic  valid_s1;
	item_t item_s1;
	kind_t kind;

	always_comb begin
		case (cmd)
			CMD_REQ_DOWNLOAD: kind = KIND_DOWNLOAD;
			CMD_TRANSFER:     kind = KIND_TRANSFER;
			CMD_EXIT:         kind = KIND_EXIT;
			default:          kind = KIND_BAD;
		endcase
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.kind            <= kind;
			item_s1.block_counter   <= block_counter;
			item_s1.payload_bytes   <= payload_bytes;
			item_s1.start_address   <= start_address;
			item_s1.total_length    <= total_length;
			item_s1.target_ok       <= target_ok;
			item_s1.payload_too_big <= {{(LIM_CMP_W-LEN_W){1'b0}}, payload_bytes} > MAX_W;
		end
	end

endmodule

FILE: hdl/ddtc_queue.sv
// ----------------------------------------------------------------------------
// ddtc_queue
// Short queue of classified requests between the front and back stages.
// ----------------------------------------------------------------------------
module ddtc_queue
	import ddtc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  item_t  push_item,
	output logic   pop_valid,
	input  logic   pop,
	output item_t  pop_item
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: hdl/ddtc_back.sv
// ----------------------------------------------------------------------------
// ddtc_back
// Session engine: apply each request to the download state and register
// the response word.
// ----------------------------------------------------------------------------
module ddtc_back
	import ddtc_pkg::*;
#(
	parameter int MAX_BLOCK_BYTES = 4095
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [LEN_W-1:0]  cfg_wr_data,
	input  logic              pop_valid,
	output logic              pop,
	input  item_t             pop_item,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           result
);

	localparam logic [LIM_CMP_W-1:0] MAX_W = LIM_CMP_W'(MAX_BLOCK_BYTES);

	logic [LEN_W-1:0]  max_block_length_q;
	logic              active_q;
	logic [CNT_W-1:0]  last_cnt_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] total_q;
	logic [ADDR_W-1:0] handled_q;
	logic              out_valid_q;
	result_t           result_q;

	result_t           res;
	logic              nxt_active;
	logic [CNT_W-1:0]  nxt_last_cnt;
	logic [ADDR_W-1:0] nxt_base;
	logic [ADDR_W-1:0] nxt_total;
	logic [ADDR_W-1:0] nxt_handled;
	logic [ADDR_W:0]   sum_handled;
	logic [LEN_W-1:0]  limit;

	assign pop       = pop_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	assign sum_handled = {1'b0, handled_q} + {{(ADDR_W+1-LEN_W){1'b0}}, pop_item.payload_bytes};
	assign limit = ({{(LIM_CMP_W-LEN_W){1'b0}}, max_block_length_q} > MAX_W) ?
		LEN_W'(MAX_W) : max_block_length_q;

	always_comb begin
		res          = '0;
		res.neg_code = NEG_NONE;
		nxt_active   = active_q;
		nxt_last_cnt = last_cnt_q;
		nxt_base     = base_q;
		nxt_total    = total_q;
		nxt_handled  = handled_q;
		case (pop_item.kind)
			KIND_DOWNLOAD: begin
				nxt_base     = pop_item.start_address;
				nxt_total    = pop_item.total_length;
				nxt_handled  = '0;
				nxt_last_cnt = '0;
				nxt_active   = 1'b1;
				if (pop_item.target_ok) begin
					res.positive    = 1'b1;
					res.block_limit = limit;
				end else begin
					res.neg_code = NEG_LENGTH;
				end
			end
			KIND_TRANSFER: begin
				if (!active_q) begin
					res.neg_code = NEG_SEQUENCE;
				end else if (pop_item.block_counter != last_cnt_q + 1'b1) begin
					nxt_active   = 1'b0;
					res.neg_code = NEG_COUNTER;
				end else if (pop_item.payload_too_big || sum_handled > {1'b0, total_q}) begin
					nxt_active   = 1'b0;
					res.neg_code = NEG_LENGTH;
				end else begin
					res.positive      = 1'b1;
					res.echo_counter  = pop_item.block_counter;
					res.write_enable  = 1'b1;
					res.write_address = base_q + handled_q;
					res.write_length  = pop_item.payload_bytes;
					nxt_handled       = sum_handled[ADDR_W-1:0];
					nxt_last_cnt      = pop_item.block_counter;
				end
			end
			KIND_EXIT: begin
				nxt_active = 1'b0;
				if (handled_q == total_q) begin
					res.positive = 1'b1;
				end else begin
					res.neg_code = NEG_LENGTH;
				end
			end
			default: begin
				res.neg_code = NEG_SEQUENCE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_block_length_q <= MAX_BLOCK_LENGTH_RST;
			active_q           <= 1'b0;
			last_cnt_q         <= '0;
			base_q             <= '0;
			total_q            <= '0;
			handled_q          <= '0;
			out_valid_q        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_block_length_q <= cfg_wr_data;
			end
			if (pop) begin
				active_q    <= nxt_active;
				last_cnt_q  <= nxt_last_cnt;
				base_q      <= nxt_base;
				total_q     <= nxt_total;
				handled_q   <= nxt_handled;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res;
		end
	end

endmodule

FILE: hdl/diag_download_transfer_control_top.sv
// ----------------------------------------------------------------------------
// diag_download_transfer_control_top
// Server side of a diagnostic download session.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one decoded request word: download
// request, transfer data block or transfer exit. Output channel
// (out_valid/out_ready) returns exactly one response word per request:
// positive or negative response, flash write command and block limit.
// cfg_wr_en/cfg_wr_data write the reported maximum block length at once.
// A request passes through the input register and the two-entry queue, whose
// head the response register loads. One word per cycle is sustained while
// the receiver keeps out_ready high; the session engine updates state and
// response together.
// When the receiver stalls, the response register holds, the queue fills
// and then in_ready drops; the input side still takes words until the
// queue and input register are full.
// Reset clears the session to idle, the queue and output valid, and sets the
// maximum block length to 1024.
// ----------------------------------------------------------------------------
module diag_download_transfer_control_top
	import ddtc_pkg::*;
#(
	parameter int MAX_BLOCK_BYTES = 4095
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LEN_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [CNT_W-1:0]   block_counter,
	input  logic [LEN_W-1:0]   payload_bytes,
	input  logic [ADDR_W-1:0]  start_address,
	input  logic [ADDR_W-1:0]  total_length,
	input  logic               target_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               positive,
	output logic [1:0]         neg_code,
	output logic [CNT_W-1:0]   echo_counter,
	output logic               write_enable,
	output logic [ADDR_W-1:0]  write_address,
	output logic [LEN_W-1:0]   write_length,
	output logic [LEN_W-1:0]   block_limit
);

	logic    push_valid;
	logic    push_ready;
	item_t   push_item;
	logic    pop_valid;
	logic    pop;
	item_t   pop_item;
	result_t result;

	ddtc_front #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.block_counter (block_counter),
		.payload_bytes (payload_bytes),
		.start_address (start_address),
		.total_length  (total_length),
		.target_ok     (target_ok),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	ddtc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	ddtc_back #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pop_valid   (pop_valid),
		.pop         (pop),
		.pop_item    (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result      (result)
	);

	assign positive      = result.positive;
	assign neg_code      = result.neg_code;
	assign echo_counter  = result.echo_counter;
	assign write_enable  = result.write_enable;
	assign write_address = result.write_address;
	assign write_length  = result.write_length;
	assign block_limit   = result.block_limit;

endmodule
